>>> src/ptg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptg_pkg;

    localparam int MAX_SEGMENTS_DEF    = 16;
    localparam int SINE_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES        = 24;
    localparam int MUL_STEPS           = 32;
    localparam int DIV_STEPS           = 57;

    localparam logic [1:0] KIND_LINEAR   = 2'd0;
    localparam logic [1:0] KIND_SINE     = 2'd1;
    localparam logic [1:0] KIND_INACTIVE = 2'd2;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EVAL,
        ST_DONE
    } ptg_state_t;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MUL,
        AR_DIV,
        AR_ANGLE,
        AR_CORDIC,
        AR_LOAD,
        AR_FIN,
        AR_DONE
    } ptg_arith_state_t;

    typedef struct packed {
        logic [23:0]        start;
        logic [23:0]        len;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [15:0]        period;
        logic [15:0]        phase;
    } ptg_entry_t;

    typedef struct packed {
        logic               is_sine;
        logic [23:0]        t;
        logic [23:0]        elapsed;
        logic [23:0]        len;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [15:0]        period;
        logic [15:0]        phase;
    } ptg_job_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } ptg_result_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/ptg_arith.sv
`timescale 1ns / 1ps
`default_nettype none

module ptg_arith
    import ptg_pkg::*;
#(
    parameter int SINE_ITERATIONS = SINE_ITERATIONS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire ptg_job_t    job,
    output ptg_result_t      res
);

    localparam int ITERS = (SINE_ITERATIONS < ATAN_ENTRIES) ? SINE_ITERATIONS : ATAN_ENTRIES;
    localparam logic [5:0] ITER_LAST = 6'(ITERS - 1);
    localparam logic [5:0] MUL_LAST  = 6'(MUL_STEPS - 1);
    localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);

    ptg_arith_state_t   state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    ptg_job_t           job_reg;
    logic [63:0]        acc_reg, mcand_reg;
    logic [31:0]        mplier_reg;
    logic               neg_reg;
    logic [56:0]        dvd_reg;
    logic [23:0]        rem_reg, dsr_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [31:0] res_reg;

    logic signed [33:0] lin_d, lin_mag, b_ext, b_mag, y_clamp, y_mag;
    logic [63:0]        acc_step;
    logic [24:0]        div_sh, div_diff;
    logic               div_ge;
    logic [31:0]        frac, angle;
    logic signed [33:0] z_raw, z_fold, dx, dy, at;
    logic signed [65:0] sp, rnd, sum_sine, sq, sum_lin;

    // operand preparation
    always_comb
    begin
        lin_d    = 34'(job.b) - 34'(job.a);
        lin_mag  = lin_d[33] ? -lin_d : lin_d;
        b_ext    = 34'(job_reg.b);
        b_mag    = b_ext[33] ? -b_ext : b_ext;
        acc_step = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
        div_sh   = {rem_reg, dvd_reg[56]};
        div_ge   = div_sh >= {1'b0, dsr_reg};
        div_diff = div_sh - {1'b0, dsr_reg};
        frac     = (job_reg.period == 16'd0) ? 32'd0 : dvd_reg[31:0];
        angle    = frac + {job_reg.phase, 16'h0000};
        z_raw    = 34'(signed'(angle));
        if (z_raw > 34'sd1073741824)
        begin
            z_fold = 34'sd2147483648 - z_raw;
        end
        else if (z_raw < -34'sd1073741824)
        begin
            z_fold = -34'sd2147483648 - z_raw;
        end
        else
        begin
            z_fold = z_raw;
        end
        dx = y_reg >>> cnt_reg[4:0];
        dy = x_reg >>> cnt_reg[4:0];
        at = signed'({4'b0000, atan_turn(cnt_reg[4:0])});
        if (y_reg > 34'sd1073741824)
        begin
            y_clamp = 34'sd1073741824;
        end
        else if (y_reg < -34'sd1073741824)
        begin
            y_clamp = -34'sd1073741824;
        end
        else
        begin
            y_clamp = y_reg;
        end
        y_mag    = y_clamp[33] ? -y_clamp : y_clamp;
        sp       = signed'({2'b00, acc_reg});
        rnd      = ((neg_reg ? -sp : sp) + 66'sd536870912) >>> 30;
        sum_sine = 66'(job_reg.a) + rnd;
        sq       = signed'({32'd0, dvd_reg[33:0]});
        sum_lin  = 66'(job_reg.a) + (neg_reg ? -sq : sq);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AR_IDLE:
            begin
                if (start)
                begin
                    if (!job.is_sine)
                    begin
                        state_next = AR_MUL;
                    end
                    else if (job.period == 16'd0)
                    begin
                        state_next = AR_ANGLE;
                    end
                    else
                    begin
                        state_next = AR_DIV;
                    end
                end
            end
            AR_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = job_reg.is_sine ? AR_FIN : AR_DIV;
                end
            end
            AR_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = job_reg.is_sine ? AR_ANGLE : AR_FIN;
                end
            end
            AR_ANGLE:  state_next = AR_CORDIC;
            AR_CORDIC:
            begin
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = AR_LOAD;
                end
            end
            AR_LOAD:   state_next = AR_MUL;
            AR_FIN:    state_next = AR_DONE;
            AR_DONE:   state_next = AR_IDLE;
            default:   state_next = AR_IDLE;
        endcase
        cnt_next = (state_next != state_reg) ? 6'd0 : cnt_reg + 6'd1;
    end

    always_comb
    begin
        res.done  = (state_reg == AR_DONE);
        res.value = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            AR_IDLE:
            begin
                if (start)
                begin
                    job_reg    <= job;
                    acc_reg    <= 64'd0;
                    mcand_reg  <= {30'd0, lin_mag};
                    mplier_reg <= {8'd0, job.elapsed};
                    neg_reg    <= lin_d[33];
                    dvd_reg    <= {1'b0, job.t, 32'd0};
                    rem_reg    <= 24'd0;
                    dsr_reg    <= {8'd0, job.period};
                end
            end
            AR_MUL:
            begin
                acc_reg    <= acc_step;
                mcand_reg  <= {mcand_reg[62:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[31:1]};
                if (cnt_reg == MUL_LAST)
                begin
                    dvd_reg <= acc_step[56:0] + 57'(job_reg.len[23:1]);
                    rem_reg <= 24'd0;
                    dsr_reg <= job_reg.len;
                end
            end
            AR_DIV:
            begin
                dvd_reg <= {dvd_reg[55:0], div_ge};
                rem_reg <= div_ge ? div_diff[23:0] : div_sh[23:0];
            end
            AR_ANGLE:
            begin
                z_reg <= z_fold;
                x_reg <= CORDIC_GAIN;
                y_reg <= 34'sd0;
            end
            AR_CORDIC:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
            end
            AR_LOAD:
            begin
                acc_reg    <= 64'd0;
                mcand_reg  <= {30'd0, b_mag};
                mplier_reg <= {1'b0, y_mag[30:0]};
                neg_reg    <= job_reg.b[31] ^ y_clamp[33];
            end
            AR_FIN:
            begin
                res_reg <= job_reg.is_sine ? sat32(sum_sine) : sat32(sum_lin);
            end
            AR_DONE:
            begin
                res_reg <= res_reg;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    // assertions
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == AR_IDLE)
        else $error("arith start while busy");
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> $past(state_reg) == AR_FIN)
        else $error("done without final step");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == AR_CORDIC |-> cnt_reg <= ITER_LAST)
        else $error("cordic count overrun");

endmodule

`default_nettype wire

>>> src/piecewise_trace_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// table write: taken whenever the block is idle, so writes run back to back
// query: a table read and a window check per entry scanned, then the result is handed over;
// a linear hit adds a 32-step multiply, a 57-step divide and a finish; a sine hit adds divide,
// angle, cordic, load, multiply and finish, with the divide skipped when the period is zero
// next beat taken the cycle after hand-over; the output register holds a result while it waits
// reset: segment count 0, every entry inactive, no result pending

module piecewise_trace_generator
    import ptg_pkg::*;
#(
    parameter int MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
    parameter int SINE_ITERATIONS = SINE_ITERATIONS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // entry_index, entry_kind, entry_start, entry_length, value_a, value_b,
    // period, phase_turns, time_ms, zero pad
    input  wire logic [175:0] s_tdata,
    // func
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // trace_value
    output logic [31:0]       m_tdata,
    // matched
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_wen,
    input  wire logic [4:0]   cfg_wdata
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    // input fields
    logic [3:0]  in_index;
    logic [1:0]  in_kind;
    logic [23:0] in_time;
    ptg_entry_t  in_entry;

    assign in_index        = s_tdata[3:0];
    assign in_kind         = s_tdata[5:4];
    assign in_entry.start  = s_tdata[29:6];
    assign in_entry.len    = s_tdata[53:30];
    assign in_entry.a      = s_tdata[85:54];
    assign in_entry.b      = s_tdata[117:86];
    assign in_entry.period = s_tdata[133:118];
    assign in_entry.phase  = s_tdata[149:134];
    assign in_time         = s_tdata[173:150];

    ptg_state_t  state_reg, state_next;
    logic [4:0]  count_reg;
    logic [IW-1:0] idx_reg, last_reg;
    logic [23:0] t_reg;

    // segment table: kinds in flops (reset to inactive), the rest in memory
    logic [1:0]  kind_reg [MAX_SEGMENTS];
    ptg_entry_t  mem [MAX_SEGMENTS];
    ptg_entry_t  rd_entry_reg;
    logic [1:0]  rd_kind_reg;

    logic signed [31:0] res_value_reg;
    logic               res_match_reg;
    logic               out_valid_reg, out_match_reg;
    logic [31:0]        out_data_reg;

    logic          in_beat, wr_en, query, push, start, hit, active, no_entries;
    logic [8:0]    n_scan, n_last;
    logic [IW+3:0] wide_index;
    logic [IW-1:0] wr_addr;
    logic [23:0]   elapsed;
    ptg_job_t      job;
    ptg_result_t   ares;

    // handshake and table write decode
    always_comb
    begin
        in_beat    = s_tvalid && s_tready;
        query      = in_beat && s_tuser[0];
        wr_en      = in_beat && !s_tuser[0] && ({5'd0, in_index} < 9'(MAX_SEGMENTS));
        wide_index = {{IW{1'b0}}, in_index};
        wr_addr    = wide_index[IW-1:0];
        // entries scanned: the smaller of the count and the table depth
        n_scan     = ({4'd0, count_reg} > 9'(MAX_SEGMENTS)) ? 9'(MAX_SEGMENTS)
                                                             : {4'd0, count_reg};
        n_last     = n_scan - 9'd1;
        no_entries = (n_scan == 9'd0);
    end

    // window check on the entry just read
    always_comb
    begin
        active  = (rd_kind_reg == KIND_LINEAR) || (rd_kind_reg == KIND_SINE);
        elapsed = t_reg - rd_entry_reg.start;
        hit     = active && (rd_entry_reg.len != 24'd0) && (t_reg >= rd_entry_reg.start)
                  && (elapsed < rd_entry_reg.len);
        job.is_sine = (rd_kind_reg == KIND_SINE);
        job.t       = t_reg;
        job.elapsed = elapsed;
        job.len     = rd_entry_reg.len;
        job.a       = rd_entry_reg.a;
        job.b       = rd_entry_reg.b;
        job.period  = rd_entry_reg.period;
        job.phase   = rd_entry_reg.phase;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query)
                begin
                    state_next = no_entries ? ST_DONE : ST_READ;
                end
            end
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (hit)
                begin
                    state_next = ST_EVAL;
                end
                else if (idx_reg == last_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EVAL:
            begin
                if (ares.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        start    = (state_reg == ST_CHECK) && hit;
        push     = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    // shared serial arithmetic: multiply, divide, cordic
    ptg_arith #(
        .SINE_ITERATIONS(SINE_ITERATIONS)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .job   (job),
        .res   (ares)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 5'd0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                kind_reg[i] <= KIND_INACTIVE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                count_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                kind_reg[wr_addr] <= in_kind;
            end
            if (query)
            begin
                idx_reg <= '0;
            end
            else if ((state_reg == ST_CHECK) && !hit && (idx_reg != last_reg))
            begin
                idx_reg <= IW'(idx_reg + 1'b1);
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_entry;
        end
        if (state_reg == ST_READ)
        begin
            rd_entry_reg <= mem[idx_reg];
            rd_kind_reg  <= kind_reg[idx_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (query)
        begin
            t_reg    <= in_time;
            last_reg <= n_last[IW-1:0];
        end
        if (query && no_entries)
        begin
            res_value_reg <= 32'sd0;
            res_match_reg <= 1'b0;
        end
        else if ((state_reg == ST_CHECK) && !hit && (idx_reg == last_reg))
        begin
            res_value_reg <= 32'sd0;
            res_match_reg <= 1'b0;
        end
        else if ((state_reg == ST_EVAL) && ares.done)
        begin
            res_value_reg <= ares.value;
            res_match_reg <= 1'b1;
        end
        if (push)
        begin
            out_data_reg  <= res_value_reg;
            out_match_reg <= res_match_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_match_reg;

    // assertions
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("unmatched result not zero");
    a_done_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ares.done |-> (state_reg == ST_EVAL))
        else $error("arith result outside evaluation");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (idx_reg <= last_reg))
        else $error("scan past last entry");
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> m_tvalid)
        else $error("result lost on push");

endmodule

`default_nettype wire

>>> verif/piecewise_trace_generator_test.sv
`timescale 1ns / 1ps

module piecewise_trace_generator_test;
    import ptg_pkg::*;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    // a fourth kind code: stored, but never matches
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    // longest query: a table read and window check per entry scanned plus a sine evaluation, with margin
    localparam int DRAIN_CYCLES = 400;
    localparam int ITEM_TARGET = 1250;
    localparam int HOLD_CYCLES = 3000;

    // one input beat, split into its fields
    typedef struct {
        logic               func;
        logic [3:0]         idx;
        logic [1:0]         kind;
        logic [23:0]        start;
        logic [23:0]        len;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [15:0]        period;
        logic [15:0]        phase;
        logic [23:0]        tm;
    } trace_beat_t;

    typedef struct {
        logic signed [31:0] value;
        logic               matched;
    } trace_result_t;

    // holds the segment table and count, predicts every query and checks the results
    class trace_scoreboard;
        logic [1:0]         kinds[16];
        logic [23:0]        starts[16];
        logic [23:0]        lens[16];
        logic signed [31:0] firsts[16];
        logic signed [31:0] seconds[16];
        logic [15:0]        periods[16];
        logic [15:0]        phases[16];
        logic [4:0]         count;
        trace_result_t      awaited[$];
        int                 errors;
        // arctangent of 2^-i in 2^-32 turn
        longint             atan_steps[24] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215,
            2608, 1304, 652, 326, 163, 81};

        function new();
            count = 0;
            errors = 0;
            foreach (kinds[i])
                kinds[i] = KIND_INACTIVE;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint linear_value(int e, longint elapsed);
            longint lo, hi, num, mag, q, span;
            logic neg;
            lo = firsts[e];
            hi = seconds[e];
            span = lens[e];
            num = (hi - lo) * elapsed;
            neg = num < 0;
            mag = neg ? -num : num;
            q = (mag + (span >> 1)) / span;
            return clamp32(lo + (neg ? -q : q));
        endfunction

        // sine in Q2.30 of a 32-bit turn fraction
        function longint sine_q30(longint angle);
            longint z, x, y, dx, dy;
            z = angle;
            x = 652032874;
            y = 0;
            if (z >= 64'sh80000000)
                z -= 64'sh100000000;
            if (z > 64'sh40000000)
                z = 64'sh80000000 - z;
            else if (z < -64'sh40000000)
                z = -64'sh80000000 - z;
            for (int i = 0; i < SINE_ITERATIONS_DEF && i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_steps[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += atan_steps[i];
                end
            end
            if (y > 64'sh40000000)
                y = 64'sh40000000;
            if (y < -64'sh40000000)
                y = -64'sh40000000;
            return y;
        endfunction

        function longint sine_value(int e, longint t);
            longint per, frac, angle, s, prod, off, amp;
            per = periods[e];
            frac = 0;
            if (per != 0)
                frac = ((t % per) << 32) / per;
            angle = (frac + (longint'(phases[e]) << 16)) & 64'hFFFFFFFF;
            s = sine_q30(angle);
            amp = seconds[e];
            off = firsts[e];
            prod = amp * s;
            return clamp32(off + ((prod + (64'sd1 <<< 29)) >>> 30));
        endfunction

        function void note_item(trace_beat_t it);
            trace_result_t r;
            int n;
            longint t, st, span;
            if (it.func == FUNC_WRITE)
            begin
                kinds[it.idx] = it.kind;
                starts[it.idx] = it.start;
                lens[it.idx] = it.len;
                firsts[it.idx] = it.a;
                seconds[it.idx] = it.b;
                periods[it.idx] = it.period;
                phases[it.idx] = it.phase;
                return;
            end
            r.value = 0;
            r.matched = 0;
            t = it.tm;
            n = (count > 16) ? 16 : count;
            for (int e = 0; e < n; e++)
            begin
                if (kinds[e] != KIND_LINEAR && kinds[e] != KIND_SINE)
                    continue;
                st = starts[e];
                span = lens[e];
                if (span == 0 || t < st || (t - st) >= span)
                    continue;
                if (kinds[e] == KIND_LINEAR)
                    r.value = 32'(linear_value(e, t - st));
                else
                    r.value = 32'(sine_value(e, t));
                r.matched = 1;
                break;
            end
            awaited.insert(awaited.size(), r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic signed [31:0] value, logic matched);
            trace_result_t exp_r;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result value %0d matched %0b", value, matched));
                return;
            end
            exp_r = awaited.pop_front();
            if (value !== exp_r.value)
                report($sformatf("trace_value %0d, want %0d", value, exp_r.value));
            if (matched !== exp_r.matched)
                report($sformatf("matched %0b, want %0b", matched, exp_r.matched));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wen = 1'b0;
    logic [4:0]   cfg_wdata = '0;

    trace_scoreboard sb = new();
    int items_sent = 0;
    int results_seen = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    // windows of the entries written in the current phase, for aiming queries
    logic [23:0] win_start[16];
    logic [23:0] win_len[16];
    int          win_count;

    piecewise_trace_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // result side: check every beat taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tuser[0]);
            results_seen++;
        end
    end

    // receiver stall pattern, with one long hold-off so the block backs up
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  held_once = 0;
    always @(negedge clk)
    begin
        if (!held_once && results_seen >= 150)
        begin
            held_once = 1;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_mode == 0)
            m_tready <= 1'b1;
        else if (stall_mode == 1)
            m_tready <= 1'($urandom_range(0, 1));
        else
            m_tready <= ($urandom_range(0, 7) == 0);
    end

    // watchdog on cycles where no beat moves
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // sends one beat; called and returns at a falling edge
    task automatic push_beat(input trace_beat_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= it.func;
        s_tdata <= {2'b00, it.tm, it.phase, it.period, it.b, it.a, it.len, it.start,
                    it.kind, it.idx};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    // stop sending, let every result come back and the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_count(input logic [4:0] n);
        cfg_wen <= 1'b1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_wen <= 1'b0;
        sb.count = n;
        @(negedge clk);
    endtask

    function automatic trace_beat_t noise_beat();
        trace_beat_t it;
        it.func = 1'($urandom_range(0, 1));
        it.idx = 4'($urandom);
        it.kind = 2'($urandom);
        it.start = 24'($urandom);
        it.len = 24'($urandom);
        it.a = $urandom;
        it.b = $urandom;
        it.period = 16'($urandom);
        it.phase = 16'($urandom);
        it.tm = 24'($urandom);
        return it;
    endfunction

    function automatic trace_beat_t seg_beat(logic [3:0] idx, logic [1:0] kind,
                                             logic [23:0] start, logic [23:0] len,
                                             logic signed [31:0] a, logic signed [31:0] b,
                                             logic [15:0] period, logic [15:0] phase);
        trace_beat_t it;
        it = noise_beat();
        it.func = FUNC_WRITE;
        it.idx = idx;
        it.kind = kind;
        it.start = start;
        it.len = len;
        it.a = a;
        it.b = b;
        it.period = period;
        it.phase = phase;
        return it;
    endfunction

    function automatic trace_beat_t query_beat(logic [23:0] tm);
        trace_beat_t it;
        it = noise_beat();
        it.func = FUNC_QUERY;
        it.tm = tm;
        return it;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 65536 * 8) - 65536 * 4;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        trace_beat_t it;
        logic [23:0] q_times[$];
        logic [1:0]  kind;
        logic [23:0] st, ln;
        logic [15:0] per;
        int          writes, queries, e;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes of values and windows, both kinds and the odd cases
        set_count(5'd16);
        push_beat(seg_beat(4'd0, KIND_LINEAR, 24'd100, 24'd100, 32'sh80000000,
                           32'sh7FFFFFFF, 16'hFFFF, 16'hFFFF));
        // zero period: angle from phase alone, a quarter turn drives it to saturation
        push_beat(seg_beat(4'd1, KIND_SINE, 24'd0, 24'd50, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                           16'd0, 16'd16384));
        push_beat(seg_beat(4'd2, KIND_SPARE, 24'd200, 24'd10, 32'sd1, 32'sd2, 16'd1, 16'd0));
        push_beat(seg_beat(4'd3, KIND_LINEAR, 24'd300, 24'd0, 32'sd5, 32'sd6, 16'd1, 16'd0));
        push_beat(seg_beat(4'd4, KIND_INACTIVE, 24'd300, 24'd10, 32'sd5, 32'sd6, 16'd1, 16'd0));
        push_beat(seg_beat(4'd5, KIND_SINE, 24'd300, 24'd100, 32'sh80000000, 32'sh80000000,
                           16'hFFFF, 16'd0));
        push_beat(seg_beat(4'd6, KIND_LINEAR, 24'hFFFFFF, 24'hFFFFFF, 32'sh7FFFFFFF,
                           32'sh80000000, 16'd0, 16'd0));
        push_beat(seg_beat(4'd15, KIND_SINE, 24'd500, 24'd100, 32'sd0, 32'sh00010000,
                           16'd1, 16'hFFFF));
        q_times = '{24'd0, 24'd25, 24'd100, 24'd150, 24'd199, 24'd200, 24'd205, 24'd300,
                    24'd350, 24'hFFFFFF, 24'd550, 24'd1000};
        foreach (q_times[i])
            push_beat(query_beat(q_times[i]));
        drain();
        set_count(5'd0);
        push_beat(query_beat(24'd25));
        drain();
        set_count(5'd31);
        push_beat(query_beat(24'd550));
        push_beat(query_beat(24'd25));

        // random phases: a new count, a batch of segments, then queries aimed at them
        while (items_sent < ITEM_TARGET)
        begin
            drain();
            case ($urandom_range(0, 5))
                0: set_count(5'd16);
                1: set_count(5'd31);
                2: set_count(5'd1);
                default: set_count(5'($urandom_range(0, 31)));
            endcase
            writes = $urandom_range(3, 16);
            win_count = 0;
            for (int w = 0; w < writes; w++)
            begin
                case ($urandom_range(0, 9))
                    0: kind = KIND_INACTIVE;
                    1: kind = KIND_SPARE;
                    2, 3, 4, 5: kind = KIND_LINEAR;
                    default: kind = KIND_SINE;
                endcase
                st = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
                ln = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 800));
                per = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 60))
                                                  : 16'($urandom);
                it = seg_beat(4'($urandom), kind, st, ln, pick_value(), pick_value(), per,
                              16'($urandom));
                push_beat(it);
                if (ln != 0)
                begin
                    win_start[win_count] = st;
                    win_len[win_count] = ln;
                    win_count++;
                end
            end
            queries = $urandom_range(20, 60);
            for (int q = 0; q < queries; q++)
            begin
                if (win_count > 0 && $urandom_range(0, 4) != 0)
                begin
                    e = $urandom_range(0, win_count - 1);
                    it = query_beat(win_start[e] + 24'($urandom % win_len[e]));
                end
                else if ($urandom_range(0, 9) == 0)
                    it = noise_beat();
                else
                    it = query_beat(24'($urandom));
                push_beat(it);
            end
        end

        drain();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
